FILE: sv/asp_pkg.sv
// Shared types and constants of the box separation push pipeline.
package asp_pkg;

    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int PUSH_W      = 32;
    localparam int M_TDATA_W   = 3 * PUSH_W;
    localparam int NUM_OPTIONS = 6;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SKIN_MARGIN   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_EPSILON = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SKIN_RESET = 16'd328;
    localparam logic [CFG_DATA_W-1:0] EPS_RESET  = 16'd1;

    // Push directions, in priority order for ties.
    typedef enum logic [2:0] {
        OPT_PX,
        OPT_NX,
        OPT_PY,
        OPT_NY,
        OPT_PZ,
        OPT_NZ
    } opt_t;

    localparam opt_t OPT_ORDER [NUM_OPTIONS] = '{OPT_PX, OPT_NX, OPT_PY, OPT_NY, OPT_PZ, OPT_NZ};

    typedef struct packed {
        logic valid;
        logic ov;
    } ctl_t;

    typedef struct packed {
        logic valid;
        logic ov;
        logic push_en;
        opt_t opt;
    } sel_t;

endpackage

FILE: sv/asp_depth.sv
// First stage: strict overlap test and the six penetration depths.
module asp_depth
    import asp_pkg::*;
#(
    parameter int COORD_BITS = 31,
    localparam int DW = COORD_BITS + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [12*COORD_BITS-1:0]  coords,
    output ctl_t                      ctl_o,
    output logic [5:0][DW-1:0]        depth_o
);

    logic signed [COORD_BITS-1:0] amn [3];
    logic signed [COORD_BITS-1:0] amx [3];
    logic signed [COORD_BITS-1:0] bmn [3];
    logic signed [COORD_BITS-1:0] bmx [3];
    logic                         ov;

    ctl_t               ctl_reg, ctl_next;
    logic [5:0][DW-1:0] depth_reg, depth_next;

    always_comb begin
        ov = 1'b1;
        for (int i = 0; i < 3; i++) begin
            amn[i] = $signed(coords[i*COORD_BITS +: COORD_BITS]);
            amx[i] = $signed(coords[(3+i)*COORD_BITS +: COORD_BITS]);
            bmn[i] = $signed(coords[(6+i)*COORD_BITS +: COORD_BITS]);
            bmx[i] = $signed(coords[(9+i)*COORD_BITS +: COORD_BITS]);
            if (!(amn[i] < bmx[i] && amx[i] > bmn[i])) begin
                ov = 1'b0;
            end
            depth_next[2*i]   = DW'(bmx[i]) - DW'(amn[i]);
            depth_next[2*i+1] = DW'(amx[i]) - DW'(bmn[i]);
        end
        ctl_next.valid = in_valid;
        ctl_next.ov    = ov;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            depth_reg <= depth_next;
        end
    end

    assign ctl_o   = ctl_reg;
    assign depth_o = depth_reg;

endmodule

FILE: sv/asp_cost.sv
// Second stage: option qualification against epsilon and cost with skin.
module asp_cost
    import asp_pkg::*;
#(
    parameter int COORD_BITS = 31,
    localparam int DW = COORD_BITS + 1,
    localparam int KW = COORD_BITS + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [CFG_DATA_W-1:0] skin,
    input  logic [CFG_DATA_W-1:0] eps,
    input  ctl_t                  ctl_i,
    input  logic [5:0][DW-1:0]    depth_i,
    output ctl_t                  ctl_o,
    output logic [5:0]            opt_valid_o,
    output logic [5:0][KW-1:0]    cost_o,
    output logic [DW-1:0]         depth_py_o
);

    ctl_t               ctl_reg;
    logic [5:0]         opt_valid_reg, opt_valid_next;
    logic [5:0][KW-1:0] cost_reg, cost_next;
    logic [DW-1:0]      depth_py_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            opt_valid_next[i] = $signed(depth_i[i]) > $signed(DW'(eps));
            cost_next[i] = KW'($signed(depth_i[i])) + KW'(skin);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            opt_valid_reg <= opt_valid_next;
            cost_reg      <= cost_next;
            depth_py_reg  <= depth_i[2];
        end
    end

    assign ctl_o       = ctl_reg;
    assign opt_valid_o = opt_valid_reg;
    assign cost_o      = cost_reg;
    assign depth_py_o  = depth_py_reg;

endmodule

FILE: sv/asp_select.sv
// Third and fourth stages: upward preference test and cheapest option search.
module asp_select
    import asp_pkg::*;
#(
    parameter int COORD_BITS = 31,
    localparam int DW = COORD_BITS + 1,
    localparam int KW = COORD_BITS + 2,
    localparam int XW = COORD_BITS + 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  ctl_t               ctl_i,
    input  logic [5:0]         opt_valid_i,
    input  logic [5:0][KW-1:0] cost_i,
    input  logic [DW-1:0]      depth_py_i,
    output sel_t               sel_o,
    output logic [KW-1:0]      sel_cost_o
);

    // Costs are compared doubled, except the upward one, so halving is exact.
    logic [5:0][XW-1:0] c2;
    logic               side_hit;
    logic [2:0]         w_valid_next;
    logic [2:0][XW-1:0] w_c2_next;
    logic [2:0][KW-1:0] w_cost_next;
    opt_t [2:0]         w_opt_next;
    logic               pick_hi;

    ctl_t               s3_ctl_reg;
    logic               take_up_reg, any_reg;
    logic [KW-1:0]      cost_py_reg;
    logic [2:0]         w_valid_reg;
    logic [2:0][XW-1:0] w_c2_reg;
    logic [2:0][KW-1:0] w_cost_reg;
    opt_t [2:0]         w_opt_reg;

    logic               b_valid;
    logic [XW-1:0]      b_c2;
    logic [KW-1:0]      b_cost;
    opt_t               b_opt;
    sel_t               sel_reg, sel_next;
    logic [KW-1:0]      sel_cost_reg, sel_cost_next;

    always_comb begin
        side_hit = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (i == 2) begin
                c2[i] = XW'($signed(cost_i[i]));
            end else begin
                c2[i] = XW'($signed(cost_i[i])) << 1;
            end
            if (i != 2 && opt_valid_i[i] &&
                $signed(c2[i]) < $signed(XW'($signed(depth_py_i)))) begin
                side_hit = 1'b1;
            end
        end
        for (int p = 0; p < 3; p++) begin
            pick_hi = !opt_valid_i[2*p] ||
                      (opt_valid_i[2*p+1] && $signed(c2[2*p+1]) < $signed(c2[2*p]));
            w_valid_next[p] = opt_valid_i[2*p] | opt_valid_i[2*p+1];
            w_c2_next[p]    = pick_hi ? c2[2*p+1] : c2[2*p];
            w_cost_next[p]  = pick_hi ? cost_i[2*p+1] : cost_i[2*p];
            w_opt_next[p]   = pick_hi ? OPT_ORDER[2*p+1] : OPT_ORDER[2*p];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctl_reg <= '0;
        end else if (adv) begin
            s3_ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            take_up_reg <= opt_valid_i[2] && !side_hit;
            any_reg     <= |opt_valid_i;
            cost_py_reg <= cost_i[2];
            w_valid_reg <= w_valid_next;
            w_c2_reg    <= w_c2_next;
            w_cost_reg  <= w_cost_next;
            w_opt_reg   <= w_opt_next;
        end
    end

    // Later groups replace the current best only when strictly cheaper.
    always_comb begin
        b_valid = w_valid_reg[0];
        b_c2    = w_c2_reg[0];
        b_cost  = w_cost_reg[0];
        b_opt   = w_opt_reg[0];
        for (int p = 1; p < 3; p++) begin
            if (w_valid_reg[p] && (!b_valid || $signed(w_c2_reg[p]) < $signed(b_c2))) begin
                b_valid = 1'b1;
                b_c2    = w_c2_reg[p];
                b_cost  = w_cost_reg[p];
                b_opt   = w_opt_reg[p];
            end
        end
        sel_next.valid   = s3_ctl_reg.valid;
        sel_next.ov      = s3_ctl_reg.ov;
        sel_next.push_en = s3_ctl_reg.ov && any_reg;
        sel_next.opt     = take_up_reg ? OPT_PY : b_opt;
        sel_cost_next    = take_up_reg ? cost_py_reg : b_cost;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
        end else if (adv) begin
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sel_cost_reg <= sel_cost_next;
        end
    end

    assign sel_o      = sel_reg;
    assign sel_cost_o = sel_cost_reg;

endmodule

FILE: sv/asp_push.sv
// Output stage: sign, saturation and routing of the push onto its axis.
module asp_push
    import asp_pkg::*;
#(
    parameter int COORD_BITS = 31,
    localparam int KW = COORD_BITS + 2,
    localparam int EW = (KW > PUSH_W) ? KW + 1 : PUSH_W + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  sel_t                 sel_i,
    input  logic [KW-1:0]        cost_i,
    output logic                 m_valid,
    output logic [M_TDATA_W-1:0] m_data,
    output logic                 m_ov
);

    localparam logic signed [EW-1:0] SAT_HI = EW'($signed(32'h7FFF_FFFF));
    localparam logic signed [EW-1:0] SAT_LO = EW'($signed(32'h8000_0000));

    logic signed [EW-1:0]     mag;
    logic signed [EW-1:0]     val;
    logic        [PUSH_W-1:0] sat;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_ov_reg;

    always_comb begin
        mag = EW'($signed(cost_i));
        val = mag;
        case (sel_i.opt)
            OPT_NX, OPT_NY, OPT_NZ: val = -mag;
            default: val = mag;
        endcase
        if (val > SAT_HI) begin
            sat = SAT_HI[PUSH_W-1:0];
        end else if (val < SAT_LO) begin
            sat = SAT_LO[PUSH_W-1:0];
        end else begin
            sat = val[PUSH_W-1:0];
        end

        m_data_next = '0;
        if (sel_i.push_en) begin
            case (sel_i.opt)
                OPT_PX, OPT_NX: m_data_next[0*PUSH_W +: PUSH_W] = sat;
                OPT_PY, OPT_NY: m_data_next[1*PUSH_W +: PUSH_W] = sat;
                OPT_PZ, OPT_NZ: m_data_next[2*PUSH_W +: PUSH_W] = sat;
                default: m_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sel_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
            m_ov_reg   <= sel_i.ov;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_ov    = m_ov_reg;

endmodule

FILE: sv/aabb_separation_push.sv
// Top level of the box separation push: config registers and five-stage pipeline.
//
// One beat on the slave channel carries two axis-aligned boxes A and B as
// twelve signed fixed-point corners; one beat on the master channel returns
// the push that moves A out of B (x, y, z, each saturated to 32 bits) and,
// on tuser, whether the boxes strictly overlapped on all three axes.
// Every input beat yields exactly one output beat, in order.
// From input acceptance to m_axis_tvalid a beat passes through depth
// subtract, cost add, preference compare, minimum combine, and the
// saturating output register. Throughput is one beat per cycle while the
// output is not stalled; the five stage registers move as one pipeline.
// When the receiver holds m_axis_tready low while a result is waiting, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost or
// repeated. A stage holding a bubble does not block the stages behind it
// once the output is free.
// skin_margin and depth_epsilon are written through cfg_we / cfg_addr /
// cfg_wdata and reset to 328 and 1. They are to be written only while the
// pipeline is empty. Reset is synchronous and clears all valid bits.
module aabb_separation_push
    import asp_pkg::*;
#(
    parameter int COORD_BITS = 31,
    localparam int S_TDATA_W = ((12 * COORD_BITS + 7) / 8) * 8,
    localparam int KW = COORD_BITS + 2,
    localparam int DW = COORD_BITS + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
    // b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z, zero fill
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // push_x, push_y, push_z
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // overlapping
    output logic                  m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    logic [CFG_DATA_W-1:0] skin_margin_reg;
    logic [CFG_DATA_W-1:0] depth_epsilon_reg;
    logic                  adv;

    ctl_t               d_ctl;
    logic [5:0][DW-1:0] d_depth;
    ctl_t               c_ctl;
    logic [5:0]         c_opt_valid;
    logic [5:0][KW-1:0] c_cost;
    logic [DW-1:0]      c_depth_py;
    sel_t               s_sel;
    logic [KW-1:0]      s_cost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skin_margin_reg   <= SKIN_RESET;
            depth_epsilon_reg <= EPS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SKIN_MARGIN:   skin_margin_reg   <= cfg_wdata;
                REG_DEPTH_EPSILON: depth_epsilon_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or being read.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    asp_depth #(.COORD_BITS(COORD_BITS)) u_depth (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .coords   (s_axis_tdata[12*COORD_BITS-1:0]),
        .ctl_o    (d_ctl),
        .depth_o  (d_depth)
    );

    asp_cost #(.COORD_BITS(COORD_BITS)) u_cost (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .skin        (skin_margin_reg),
        .eps         (depth_epsilon_reg),
        .ctl_i       (d_ctl),
        .depth_i     (d_depth),
        .ctl_o       (c_ctl),
        .opt_valid_o (c_opt_valid),
        .cost_o      (c_cost),
        .depth_py_o  (c_depth_py)
    );

    asp_select #(.COORD_BITS(COORD_BITS)) u_select (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .ctl_i       (c_ctl),
        .opt_valid_i (c_opt_valid),
        .cost_i      (c_cost),
        .depth_py_i  (c_depth_py),
        .sel_o       (s_sel),
        .sel_cost_o  (s_cost)
    );

    asp_push #(.COORD_BITS(COORD_BITS)) u_push (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .sel_i   (s_sel),
        .cost_i  (s_cost),
        .m_valid (m_axis_tvalid),
        .m_data  (m_axis_tdata),
        .m_ov    (m_axis_tuser)
    );

endmodule

FILE: sv/asp_checker.sv
// Port-level checks of the box separation push, bound to the top level.
module asp_checker
    import asp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    logic px_nz, py_nz, pz_nz;

    assign px_nz = m_axis_tdata[0*PUSH_W +: PUSH_W] != '0;
    assign py_nz = m_axis_tdata[1*PUSH_W +: PUSH_W] != '0;
    assign pz_nz = m_axis_tdata[2*PUSH_W +: PUSH_W] != '0;

    // A synchronous reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A held result keeps its value until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Boxes that do not overlap never get pushed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("push without overlap");

    // The push acts along at most one axis.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $countones({px_nz, py_nz, pz_nz}) <= 1)
        else $error("push on more than one axis");

    // A free output always lets a new beat in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind aabb_separation_push asp_checker u_asp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
